// ===== rtl/lsla_pkg.sv =====
package lsla_pkg;

	localparam logic [3:0] ACT_NONE = 4'd0;
	localparam logic [3:0] ACT_LB   = 4'd1;
	localparam logic [3:0] ACT_LBU  = 4'd2;
	localparam logic [3:0] ACT_LH   = 4'd3;
	localparam logic [3:0] ACT_LHU  = 4'd4;
	localparam logic [3:0] ACT_LW   = 4'd5;
	localparam logic [3:0] ACT_LWL  = 4'd6;
	localparam logic [3:0] ACT_LWR  = 4'd7;
	localparam logic [3:0] ACT_SB   = 4'd8;
	localparam logic [3:0] ACT_SH   = 4'd9;
	localparam logic [3:0] ACT_SW   = 4'd10;
	localparam logic [3:0] ACT_SWL  = 4'd11;
	localparam logic [3:0] ACT_SWR  = 4'd12;
	localparam logic [3:0] ACT_SC   = 4'd13;

	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	typedef struct packed {
		logic [3:0]  action;
		logic [1:0]  addr_low;
		logic [31:0] mem_word;
		logic [31:0] reg_value;
	} lsla_in_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic        result_valid;
		logic        store_enable;
		logic [31:0] store_word;
		logic [3:0]  lane_mask;
	} lsla_out_t;

endpackage

// ===== rtl/lsla_align.sv =====
module lsla_align (
	input  lsla_pkg::lsla_in_t  item,
	output lsla_pkg::lsla_out_t result
);
	import lsla_pkg::*;

	logic [4:0]  bsh;
	logic [4:0]  hsh;
	logic [4:0]  lsh;
	logic [31:0] mem_shr;
	logic [31:0] half_shr;
	logic [31:0] m;

	// byte offset, halfword offset and the left-merge offset (24 - 8*a)
	assign bsh      = {item.addr_low, 3'b000};
	assign hsh      = {item.addr_low[1], 4'b0000};
	assign lsh      = {~item.addr_low, 3'b000};
	assign mem_shr  = item.mem_word >> bsh;
	assign half_shr = item.mem_word >> hsh;

	always_comb begin
		result = '0;
		m      = '0;
		unique case (item.action)
			ACT_LB: begin
				result.result_word  = {{24{mem_shr[7]}}, mem_shr[7:0]};
				result.result_valid = 1'b1;
			end
			ACT_LBU: begin
				result.result_word  = {24'd0, mem_shr[7:0]};
				result.result_valid = 1'b1;
			end
			ACT_LH: begin
				result.result_word  = {{16{half_shr[15]}}, half_shr[15:0]};
				result.result_valid = 1'b1;
			end
			ACT_LHU: begin
				result.result_word  = {16'd0, half_shr[15:0]};
				result.result_valid = 1'b1;
			end
			ACT_LW: begin
				result.result_word  = item.mem_word;
				result.result_valid = 1'b1;
			end
			ACT_LWL: begin
				m = ALL_ONES << lsh;
				result.result_word  = ((item.mem_word << lsh) & m) | (item.reg_value & ~m);
				result.result_valid = 1'b1;
			end
			ACT_LWR: begin
				m = ALL_ONES >> bsh;
				result.result_word  = (mem_shr & m) | (item.reg_value & ~m);
				result.result_valid = 1'b1;
			end
			ACT_SB: begin
				m = 32'h0000_00ff << bsh;
				result.store_word   = ((item.reg_value << bsh) & m) | (item.mem_word & ~m);
				result.lane_mask    = 4'b0001 << item.addr_low;
				result.store_enable = 1'b1;
			end
			ACT_SH: begin
				m = 32'h0000_ffff << hsh;
				result.store_word   = ((item.reg_value << hsh) & m) | (item.mem_word & ~m);
				result.lane_mask    = 4'b0011 << {item.addr_low[1], 1'b0};
				result.store_enable = 1'b1;
			end
			ACT_SW: begin
				result.store_word   = item.reg_value;
				result.lane_mask    = 4'hf;
				result.store_enable = 1'b1;
			end
			ACT_SWL: begin
				m = ALL_ONES >> lsh;
				result.store_word   = ((item.reg_value >> lsh) & m) | (item.mem_word & ~m);
				result.lane_mask    = 4'hf >> (~item.addr_low);
				result.store_enable = 1'b1;
			end
			ACT_SWR: begin
				m = ALL_ONES << bsh;
				result.store_word   = ((item.reg_value << bsh) & m) | (item.mem_word & ~m);
				result.lane_mask    = 4'hf << item.addr_low;
				result.store_enable = 1'b1;
			end
			ACT_SC: begin
				// conditional store always succeeds
				result.store_word   = item.reg_value;
				result.lane_mask    = 4'hf;
				result.store_enable = 1'b1;
				result.result_word  = 32'd1;
				result.result_valid = 1'b1;
			end
			default: begin
				// no operation and unused codes: drive all zeros
				result = '0;
			end
		endcase
	end

endmodule

// ===== rtl/load_store_lane_align.sv =====
// Load/store lane alignment for a little-endian MIPS32 memory stage. A
// transaction is taken on every clock where start is high (busy is never
// raised) and its result appears on result, flagged by done for exactly one
// cycle. It passes the input register and then the result register, with
// combinational lane shifting and merging between them. Throughput is one
// transaction per clock. The receiver must take each result as it comes.
module load_store_lane_align (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lsla_pkg::lsla_in_t  item,
	output logic                done,
	output lsla_pkg::lsla_out_t result
);
	import lsla_pkg::*;

	logic      valid_s1;
	lsla_in_t  item_s1;
	lsla_out_t comb_out;
	logic      valid_s2;
	lsla_out_t result_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// hold payload when no transaction moves
	always_ff @(posedge clk) begin
		if (start) begin
			item_s1 <= item;
		end
		if (valid_s1) begin
			result_s2 <= comb_out;
		end
	end

	lsla_align u_align (
		.item   (item_s1),
		.result (comb_out)
	);

	assign done   = valid_s2;
	assign result = result_s2;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import lsla_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	lsla_in_t   item;
	logic       done;
	lsla_out_t  result;

	lsla_out_t  lane_q[$];
	int         idle_pct;
	int         sent_cnt;
	int         checked_cnt;
	int         fail_cnt;

	load_store_lane_align dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Expected lane alignment for one transaction
	function automatic lsla_out_t align_lanes(input lsla_in_t op);
		lsla_out_t   r;
		logic [31:0] m;
		logic [7:0]  b;
		logic [15:0] h;
		int unsigned bsh;
		int unsigned hsh;
		int unsigned lsh;
		r   = '0;
		bsh = op.addr_low * 8;
		hsh = op.addr_low[1] ? 16 : 0;
		lsh = 24 - bsh;
		b   = 8'(op.mem_word >> bsh);
		h   = 16'(op.mem_word >> hsh);
		case (op.action)
			ACT_LB: begin
				r.result_word  = {{24{b[7]}}, b};
				r.result_valid = 1'b1;
			end
			ACT_LBU: begin
				r.result_word  = {24'd0, b};
				r.result_valid = 1'b1;
			end
			ACT_LH: begin
				r.result_word  = {{16{h[15]}}, h};
				r.result_valid = 1'b1;
			end
			ACT_LHU: begin
				r.result_word  = {16'd0, h};
				r.result_valid = 1'b1;
			end
			ACT_LW: begin
				r.result_word  = op.mem_word;
				r.result_valid = 1'b1;
			end
			ACT_LWL: begin
				m = ALL_ONES << lsh;
				r.result_word  = ((op.mem_word << lsh) & m) | (op.reg_value & ~m);
				r.result_valid = 1'b1;
			end
			ACT_LWR: begin
				m = ALL_ONES >> bsh;
				r.result_word  = ((op.mem_word >> bsh) & m) | (op.reg_value & ~m);
				r.result_valid = 1'b1;
			end
			ACT_SB: begin
				m = 32'h0000_00ff << bsh;
				r.store_word   = ((op.reg_value << bsh) & m) | (op.mem_word & ~m);
				r.lane_mask    = 4'b0001 << op.addr_low;
				r.store_enable = 1'b1;
			end
			ACT_SH: begin
				m = 32'h0000_ffff << hsh;
				r.store_word   = ((op.reg_value << hsh) & m) | (op.mem_word & ~m);
				r.lane_mask    = 4'b0011 << (hsh / 8);
				r.store_enable = 1'b1;
			end
			ACT_SW: begin
				r.store_word   = op.reg_value;
				r.lane_mask    = 4'hf;
				r.store_enable = 1'b1;
			end
			ACT_SWL: begin
				m = ALL_ONES >> lsh;
				r.store_word   = ((op.reg_value >> lsh) & m) | (op.mem_word & ~m);
				r.lane_mask    = 4'hf >> (lsh / 8);
				r.store_enable = 1'b1;
			end
			ACT_SWR: begin
				m = ALL_ONES << bsh;
				r.store_word   = ((op.reg_value << bsh) & m) | (op.mem_word & ~m);
				r.lane_mask    = 4'hf << op.addr_low;
				r.store_enable = 1'b1;
			end
			ACT_SC: begin
				r.store_word   = op.reg_value;
				r.lane_mask    = 4'hf;
				r.store_enable = 1'b1;
				r.result_word  = 32'd1;
				r.result_valid = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// Record accepted transactions and compare each done strobe with the oldest one
	always @(posedge clk) begin
		lsla_out_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (lane_q.size() == 0) begin
					$error("result with nothing pending");
					fail_cnt++;
				end else begin
					exp_r = lane_q.pop_front();
					check_field("result_word", exp_r.result_word, result.result_word);
					check_field("result_valid", 32'(exp_r.result_valid),
						32'(result.result_valid));
					check_field("store_enable", 32'(exp_r.store_enable),
						32'(result.store_enable));
					check_field("store_word", exp_r.store_word, result.store_word);
					check_field("lane_mask", 32'(exp_r.lane_mask), 32'(result.lane_mask));
					checked_cnt++;
				end
			end
			if (start && !busy)
				lane_q.push_back(align_lanes(item));
		end
	end

	// Hold start low for random gaps, then present op until accepted
	task automatic send_op(input lsla_in_t op);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			item  <= '{4'($urandom), 2'($urandom), $urandom, $urandom};
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= op;
		do @(posedge clk); while (busy);
		sent_cnt++;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;
			1:       return ALL_ONES;
			2:       return 32'h8080_8080;
			3:       return 32'h7f7f_7f7f;
			default: return $urandom;
		endcase
	endfunction

	function automatic lsla_in_t pick_op();
		lsla_in_t op;
		if ($urandom_range(9) == 0)
			op.action = 4'($urandom_range(2) == 0 ? ACT_NONE : 14 + $urandom_range(1));
		else
			op.action = 4'($urandom_range(ACT_SC, ACT_LB));
		op.addr_low  = 2'($urandom_range(3));
		op.mem_word  = pick_word();
		op.reg_value = pick_word();
		return op;
	endfunction

	task automatic test_directed();
		lsla_in_t op;
		idle_pct = 0;
		// every code, including none and the unused ones, with the address rotating
		for (int a = 0; a < 16; a++) begin
			op.action    = 4'(a);
			op.addr_low  = 2'(a % 4);
			op.mem_word  = 32'h80ff_7f01;
			op.reg_value = 32'hc3a5_5a3c;
			send_op(op);
		end
		// misaligned halfword and word accesses
		send_op('{ACT_LH,  2'd1, 32'h8001_7ffe, 32'h0});
		send_op('{ACT_LHU, 2'd3, 32'h8001_7ffe, 32'h0});
		send_op('{ACT_SH,  2'd3, 32'h1234_5678, 32'hffff_8001});
		send_op('{ACT_LW,  2'd3, 32'hdead_beef, 32'h0});
		send_op('{ACT_SW,  2'd1, 32'h0, 32'hcafe_f00d});
		send_op('{ACT_SC,  2'd2, ALL_ONES, 32'h0});
		// field extremes
		send_op('{ACT_LWL, 2'd0, ALL_ONES, 32'h0});
		send_op('{ACT_LWR, 2'd3, 32'h0, ALL_ONES});
		send_op('{ACT_SWL, 2'd3, 32'h0, ALL_ONES});
		send_op('{ACT_SWR, 2'd0, ALL_ONES, 32'h0});
	endtask

	task automatic test_random(input int n, input int pct);
		idle_pct = pct;
		repeat (n) send_op(pick_op());
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		idle_pct    = 0;
		sent_cnt    = 0;
		checked_cnt = 0;
		fail_cnt    = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(180, 0);
		test_random(180, 82);
		test_random(180, 0);
		test_random(180, 21);

		@(negedge clk);
		start <= 1'b0;
		while (lane_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered all action codes and lane offsets over %0d transactions", sent_cnt);
		$display("%0d results compared, %0d mismatches", checked_cnt, fail_cnt);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
